FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, opcodes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH    = 16;
    localparam int RES_BITS = 33;
    localparam int MAG_BITS = RES_BITS;
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);
    localparam int QDEPTH   = 2;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_NEG    = 3'd5,
        OP_INC    = 3'd6,
        OP_DEC    = 3'd7
    } opcode_t;

    // One classified job: unreduced fraction plus the final adjustment.
    typedef struct packed {
        logic [RES_BITS-1:0] num;
        logic [RES_BITS-1:0] den;
        logic                inc;
        logic                dec;
    } job_t;

endpackage

FILE: rtl/rau_if.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Valid/ready interfaces for the operand and result beats.
// ----------------------------------------------------------------------------
interface rau_in_if;
    import rau_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [2:0]              opcode;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;
    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    import rau_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [RES_BITS-1:0] res_num;
    logic signed [RES_BITS-1:0] res_den;
    logic                       zero_gcd;
    modport source (output valid, res_num, res_den, zero_gcd, input ready);
    modport sink   (input valid, res_num, res_den, zero_gcd, output ready);
endinterface

FILE: rtl/rau_front.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts operand beats and forms the unreduced fraction over two stages.
// ----------------------------------------------------------------------------
module rau_front
    import rau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rau_in_if.sink in_ch,
    output logic  job_valid,
    input  logic  job_ready,
    output job_t  job
);

    localparam int PW = 2 * WIDTH;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_OUT  = 3'b100
    } fstate_t;

    fstate_t             state_reg, state_next;
    opcode_t             op_reg;
    logic signed [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    job_t                job_next;
    logic signed [PW-1:0] m0_a, m0_b, m1_a, m1_b, m2_a, m2_b;
    logic signed [RES_BITS-1:0] p0x, p1x, p2x;

    assign in_ch.ready = (state_reg == F_IDLE);
    assign job_valid   = (state_reg == F_OUT);
    assign job         = job_next;

    // Operand selection for the three products.
    always_comb
    begin
        m0_a = PW'(an_reg); m0_b = PW'(bd_reg);
        m1_a = PW'(bn_reg); m1_b = PW'(ad_reg);
        m2_a = PW'(ad_reg); m2_b = PW'(bd_reg);
        case (op_reg)
            OP_MUL:
            begin
                m0_b = PW'(bn_reg);
            end
            OP_DIV:
            begin
                m2_b = PW'(bn_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign p0x = RES_BITS'(p0_reg);
    assign p1x = RES_BITS'(p1_reg);
    assign p2x = RES_BITS'(p2_reg);

    // Combine products into the fraction to reduce.
    always_comb
    begin
        job_next.num = RES_BITS'(an_reg);
        job_next.den = RES_BITS'(ad_reg);
        job_next.inc = (op_reg == OP_INC);
        job_next.dec = (op_reg == OP_DEC);
        case (op_reg)
            OP_ADD:
            begin
                job_next.num = p0x + p1x;
                job_next.den = p2x;
            end
            OP_SUB:
            begin
                job_next.num = p0x - p1x;
                job_next.den = p2x;
            end
            OP_MUL, OP_DIV:
            begin
                job_next.num = p0x;
                job_next.den = p2x;
            end
            OP_NEG:
            begin
                job_next.num = -RES_BITS'(an_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (in_ch.valid) state_next = F_MUL;
            F_MUL:   state_next = F_OUT;
            F_OUT:   if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Operand capture and product registers.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg <= opcode_t'(in_ch.opcode);
            an_reg <= in_ch.a_num;
            ad_reg <= in_ch.a_den;
            bn_reg <= in_ch.b_num;
            bd_reg <= in_ch.b_den;
        end
        if (state_reg == F_MUL)
        begin
            p0_reg <= m0_a * m0_b;
            p1_reg <= m1_a * m1_b;
            p2_reg <= m2_a * m2_b;
        end
    end

endmodule

FILE: rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit job queue
// Small FIFO that decouples the front end from the reduction engine.
// ----------------------------------------------------------------------------
module rau_queue
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    localparam int PW = $clog2(QDEPTH);

    job_t                mem_reg [QDEPTH];
    logic [PW-1:0]       wptr_reg, rptr_reg;
    logic [PW:0]         cnt_reg;
    logic                push, pop;

    assign wr_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/rau_back.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit reduction engine
// Binary gcd, then two restoring divisions, then the increment or decrement fix-up.
// ----------------------------------------------------------------------------
module rau_back
    import rau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    rau_out_if.source out_ch
);

    localparam int M = MAG_BITS;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_GCD   = 6'b000010,
        B_DIVN  = 6'b000100,
        B_DIVD  = 6'b001000,
        B_FIX   = 6'b010000,
        B_OUT   = 6'b100000
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic [M-1:0]      u_reg, v_reg, g_reg;
    logic [CNT_BITS-1:0] k_reg, i_reg;
    logic [M-1:0]      rem_reg, quo_reg, dvd_reg;
    logic [M-1:0]      qn_reg;
    logic              nneg_reg, dneg_reg, inc_reg, dec_reg;
    logic [RES_BITS-1:0] num_reg, den_reg, rnum_reg, rden_reg;
    logic              zero_reg;
    logic [M-1:0]      nmag, dmag, umin, vdiff;
    logic [M:0]        trial;
    logic [M-1:0]      rem_sh, qfin, rnum_w, rden_w;

    assign nmag = job.num[RES_BITS-1] ? -job.num : job.num;
    assign dmag = job.den[RES_BITS-1] ? -job.den : job.den;

    assign job_ready       = (state_reg == B_IDLE);
    assign out_ch.valid    = (state_reg == B_OUT);
    assign out_ch.res_num  = rnum_reg;
    assign out_ch.res_den  = rden_reg;
    assign out_ch.zero_gcd = zero_reg;

    // One binary gcd step: strip common twos, then subtract.
    assign umin  = (u_reg < v_reg) ? u_reg : v_reg;
    assign vdiff = (u_reg < v_reg) ? v_reg - u_reg : u_reg - v_reg;

    // One restoring division step.
    assign rem_sh = {rem_reg[M-2:0], dvd_reg[M-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, g_reg};
    assign qfin   = {quo_reg[M-2:0], ~trial[M]};

    // The denominator quotient stays in quo_reg after the last step.
    assign rnum_w = nneg_reg ? -qn_reg : qn_reg;
    assign rden_w = dneg_reg ? -quo_reg : quo_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (job_valid) state_next = B_GCD;
            B_GCD:
            begin
                if (u_reg == '0 || v_reg == '0 || u_reg == v_reg)
                    state_next = B_DIVN;
            end
            B_DIVN:
            begin
                if (g_reg == '0) state_next = B_FIX;
                else if (i_reg == CNT_BITS'(M - 1)) state_next = B_DIVD;
            end
            B_DIVD: if (i_reg == CNT_BITS'(M - 1)) state_next = B_FIX;
            B_FIX:  state_next = B_OUT;
            B_OUT:  if (out_ch.ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers for gcd, divisions and result.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                u_reg    <= nmag;
                v_reg    <= dmag;
                k_reg    <= '0;
                num_reg  <= job.num;
                den_reg  <= job.den;
                nneg_reg <= job.num[RES_BITS-1];
                dneg_reg <= job.den[RES_BITS-1];
                inc_reg  <= job.inc;
                dec_reg  <= job.dec;
            end
            B_GCD:
            begin
                if (u_reg == '0 || v_reg == '0 || u_reg == v_reg)
                begin
                    g_reg   <= (u_reg | v_reg) << k_reg;
                    i_reg   <= '0;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dvd_reg <= nneg_reg ? -num_reg : num_reg;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else
                begin
                    u_reg <= umin;
                    v_reg <= vdiff >> 1;
                end
            end
            B_DIVN, B_DIVD:
            begin
                rem_reg <= trial[M] ? rem_sh : trial[M-1:0];
                quo_reg <= qfin;
                dvd_reg <= {dvd_reg[M-2:0], 1'b0};
                i_reg   <= i_reg + 1'b1;
                if (i_reg == CNT_BITS'(M - 1))
                begin
                    i_reg <= '0;
                    if (state_reg == B_DIVN)
                    begin
                        rem_reg <= '0;
                        quo_reg <= '0;
                        qn_reg  <= qfin;
                        dvd_reg <= dneg_reg ? -den_reg : den_reg;
                    end
                end
            end
            B_FIX:
            begin
                zero_reg <= (g_reg == '0);
                if (g_reg == '0)
                begin
                    rnum_reg <= '0;
                    rden_reg <= '0;
                end
                else
                begin
                    rden_reg <= rden_w;
                    if (inc_reg)      rnum_reg <= rnum_w + rden_w;
                    else if (dec_reg) rnum_reg <= rnum_w - rden_w;
                    else              rnum_reg <= rnum_w;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/rational_arithmetic_unit.sv
// Flow: the front end captures the operands and registers the products, the job
// passes through the queue, then the reduction engine loads it, runs the gcd,
// divides by it (skipped when the gcd is zero) and applies the fix-up.
// Throughput: one beat per reduction, set by the serial gcd and divider;
// the front end prepares the next job while the engine works.
// Reset: rst_n clears all control state asynchronously; queue empties.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add/sub/mul/div/negate with gcd reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);

    logic f_valid, f_ready, q_valid, q_ready;
    job_t f_job, q_job;

    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_ch(out_ch)
    );

    // A zero gcd result is always 0/0.
    a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.zero_gcd |-> out_ch.res_num == '0 && out_ch.res_den == '0)
        else $error("zero gcd with nonzero result");

    // A result held under backpressure stays valid and keeps its numerator.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.res_num))
        else $error("result changed while stalled");

    // Queue never hands a job while the engine is busy.
    a_q: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> !q_ready)
        else $error("engine accepted two jobs back to back");

endmodule
